// ===== hdl/rras_pkg.sv =====
package rras_pkg;

  // logical ports served by the scheduler
  localparam int PORTS = 4;
  localparam int PORT_W = $clog2(PORTS);
  // ports that have a slot in the channel and client map registers
  localparam int MAP_SLOTS = 4;

  localparam logic [1:0] CHANNEL_MAP_RESET = 2'd0;
  localparam logic [7:0] CHANNEL_MAP_RST = 8'hE4;
  localparam logic [31:0] CLIENT_MAP_RST = 32'hFFFF_FFFF;
  localparam logic [7:0] NO_CLIENT = 8'hFF;

  typedef enum logic {
    CMD_REQUEST = 1'b0,
    CMD_DONE    = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_BUSY       = 3'd1,
    ST_INVALID    = 3'd2,
    ST_DATA_READY = 3'd3,
    ST_SPURIOUS   = 3'd4
  } status_e;

  typedef enum logic {
    CFG_CHANNEL_MAP = 1'b0,
    CFG_CLIENT_MAP  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic       cmd;
    logic [3:0] port;
    logic [9:0] sample;
  } in_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic       start_conversion;
    logic [1:0] start_channel;
    logic [1:0] done_port;
    logic [7:0] done_client;
    logic [9:0] done_value;
  } out_rsp_t;

  typedef struct packed {
    logic [7:0]  channel_map;
    logic [31:0] client_map;
  } map_regs_t;

  // hardware channel of a logical port, channel 0 beyond the map
  function automatic logic [1:0] chan_of(input logic [PORT_W-1:0] p,
                                         input logic [7:0] map);
    logic [1:0] slot;
    slot = 2'(p);
    if (32'(p) >= MAP_SLOTS) begin
      return CHANNEL_MAP_RESET;
    end
    return map[{slot, 1'b0} +: 2];
  endfunction

  // client id of a logical port, no client beyond the map
  function automatic logic [7:0] client_of(input logic [PORT_W-1:0] p,
                                           input logic [31:0] map);
    logic [1:0] slot;
    slot = 2'(p);
    if (32'(p) >= MAP_SLOTS) begin
      return NO_CLIENT;
    end
    return map[{slot, 3'b000} +: 8];
  endfunction

endpackage

// ===== hdl/round_robin_adc_request_scheduler.sv =====
// an accepted request moves from the input register to the output register
// throughput: one request per cycle while the result channel does not stall;
//   the round-robin search over the pending mask is a single combinational
//   pass between the input and result registers
// reset: asynchronous active low; clears pending mask, current port and both
//   stage valids, and loads the default channel and client maps
module round_robin_adc_request_scheduler
  import rras_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_req_t     in_req_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_rsp_t    out_rsp_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  map_regs_t maps;

  // input register stage
  logic    in_valid_q;
  in_req_t in_req_q;

  // result register stage
  logic     out_valid_q;
  out_rsp_t out_rsp_q;
  out_rsp_t rsp_d;

  logic out_free;   // result register can take a new value this cycle
  logic fire;       // registered request gets processed this cycle
  logic in_take;    // input register loads a new request

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  // input register drains whenever its request moves on
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  rras_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .maps_o      (maps)
  );

  // scheduling state and the per-request decision
  rras_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_req_q),
    .maps_i (maps),
    .rsp_o  (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (out_free || !in_valid_q) begin
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  // result payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== hdl/rras_cfg_regs.sv =====
module rras_cfg_regs
  import rras_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output map_regs_t   maps_o
);

  logic [7:0]  channel_map_q;
  logic [31:0] client_map_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_map_q <= CHANNEL_MAP_RST;
      client_map_q  <= CLIENT_MAP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CHANNEL_MAP: channel_map_q <= cfg_data_i[7:0];
        CFG_CLIENT_MAP:  client_map_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign maps_o.channel_map = channel_map_q;
  assign maps_o.client_map  = client_map_q;

endmodule

// ===== hdl/rras_core.sv =====
module rras_core
  import rras_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_req_t   req_i,
  input  map_regs_t maps_i,
  output out_rsp_t  rsp_o
);

  logic [PORTS-1:0]  pending_q, pending_d;
  logic [PORT_W-1:0] current_q, current_d;

  always_comb begin
    logic [PORT_W-1:0] pidx;
    logic [PORTS-1:0]  cleared;
    logic [PORT_W:0]   cand;
    logic [PORT_W-1:0] next_port;
    logic              found;

    rsp_o     = '0;
    pending_d = pending_q;
    current_d = current_q;
    pidx      = req_i.port[PORT_W-1:0];
    cleared   = pending_q & ~(PORTS'(1) << current_q);
    next_port = current_q;
    found     = 1'b0;

    // rotating priority: first pending port after the finished one
    for (int i = 1; i <= PORTS; i++) begin
      cand = {1'b0, current_q} + (PORT_W + 1)'(i);
      if (32'(cand) >= PORTS) begin
        cand = cand - (PORT_W + 1)'(PORTS);
      end
      if (!found && cleared[cand[PORT_W-1:0]]) begin
        found     = 1'b1;
        next_port = cand[PORT_W-1:0];
      end
    end

    if (cmd_e'(req_i.cmd) == CMD_REQUEST) begin
      if (32'(req_i.port) >= PORTS) begin
        rsp_o.status = ST_INVALID;
      end else if (pending_q[pidx]) begin
        rsp_o.status = ST_BUSY;
      end else begin
        rsp_o.status = ST_ACCEPTED;
        pending_d    = pending_q | (PORTS'(1) << pidx);
        if (pending_q == '0) begin
          current_d              = pidx;
          rsp_o.start_conversion = 1'b1;
          rsp_o.start_channel    = chan_of(pidx, maps_i.channel_map);
        end
      end
    end else if (pending_q == '0) begin
      rsp_o.status = ST_SPURIOUS;
    end else begin
      rsp_o.status      = ST_DATA_READY;
      pending_d         = cleared;
      rsp_o.done_port   = 2'(current_q);
      rsp_o.done_client = client_of(current_q, maps_i.client_map);
      rsp_o.done_value  = req_i.sample;
      if (found) begin
        current_d              = next_port;
        rsp_o.start_conversion = 1'b1;
        rsp_o.start_channel    = chan_of(next_port, maps_i.channel_map);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      current_q <= '0;
    end else if (fire_i) begin
      pending_q <= pending_d;
      current_q <= current_d;
    end
  end

endmodule

// ===== hdl/rras_checker.sv =====
module rras_checker
  import rras_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_rsp_t    out_rsp_o
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.status <= ST_SPURIOUS)
    else $error("status code out of range");

  a_chan_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.start_conversion |-> out_rsp_o.start_channel == '0)
    else $error("channel set without a start");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_DATA_READY |->
      out_rsp_o.done_port == '0 && out_rsp_o.done_client == '0 &&
      out_rsp_o.done_value == '0)
    else $error("done fields set without data ready");

  // rejected or spurious requests never start the converter
  a_no_start_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == ST_BUSY || out_rsp_o.status == ST_INVALID ||
      out_rsp_o.status == ST_SPURIOUS) |-> !out_rsp_o.start_conversion)
    else $error("start on a rejected request");

endmodule

bind round_robin_adc_request_scheduler rras_checker u_rras_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import rras_pkg::*;

  // generous bound: the 522 requests with stalls fit many times over
  localparam int RUN_LIMIT_NS = 2_000_000;
  localparam int PHASE_REQUESTS = 100;
  localparam int PHASES = 5;

  // tracks the scheduler state and the responses still owed by the dut
  class conversion_scoreboard;
    logic [PORTS-1:0]  pend_mask;
    logic [PORT_W-1:0] cur_port;
    logic [7:0]        chan_map;
    logic [31:0]       client_map;
    out_rsp_t          rsp_due[$];
    int                mismatches;

    function new();
      pend_mask  = '0;
      cur_port   = '0;
      chan_map   = CHANNEL_MAP_RST;
      client_map = CLIENT_MAP_RST;
      mismatches = 0;
    endfunction

    function void write_map(cfg_idx_e idx, logic [31:0] data);
      if (idx == CFG_CHANNEL_MAP) begin
        chan_map = data[7:0];
      end else begin
        client_map = data;
      end
    endfunction

    function logic [1:0] channel_for(int p);
      if (p >= MAP_SLOTS) begin
        return 2'd0;
      end
      return chan_map[2*p +: 2];
    endfunction

    function logic [PORTS-1:0] pending_ports();
      return pend_mask;
    endfunction

    function int outstanding();
      return rsp_due.size();
    endfunction

    // advance the scheduler state by one accepted request, queue its response
    function void note_request(in_req_t r);
      out_rsp_t rsp;
      int       p;
      rsp = '0;
      if (r.cmd == CMD_REQUEST) begin
        if (int'(r.port) >= PORTS) begin
          rsp.status = ST_INVALID;
        end else if (pend_mask[r.port]) begin
          rsp.status = ST_BUSY;
        end else begin
          rsp.status = ST_ACCEPTED;
          // converter idle: start right away
          if (pend_mask == '0) begin
            cur_port              = r.port[PORT_W-1:0];
            rsp.start_conversion  = 1'b1;
            rsp.start_channel     = channel_for(int'(r.port));
          end
          pend_mask[r.port] = 1'b1;
        end
      end else if (pend_mask == '0) begin
        rsp.status = ST_SPURIOUS;
      end else begin
        pend_mask[cur_port] = 1'b0;
        rsp.status      = ST_DATA_READY;
        rsp.done_port   = 2'(cur_port);
        rsp.done_client = (int'(cur_port) >= MAP_SLOTS) ? NO_CLIENT
                                                         : client_map[8*cur_port +: 8];
        rsp.done_value  = r.sample;
        // rotate from the port after the finished one
        if (pend_mask != '0) begin
          p = int'(cur_port);
          for (int i = 0; i < PORTS; i++) begin
            p = (p + 1 >= PORTS) ? 0 : p + 1;
            if (pend_mask[p]) break;
          end
          cur_port             = PORT_W'(p);
          rsp.start_conversion = 1'b1;
          rsp.start_channel    = channel_for(p);
        end
      end
      rsp_due.push_back(rsp);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_field(string name, int got, int want);
      if (got != want) begin
        report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
      end
    endtask

    task check_response(out_rsp_t got);
      out_rsp_t want;
      if (rsp_due.size() == 0) begin
        report_mismatch("response with no request outstanding");
        return;
      end
      want = rsp_due.pop_front();
      if ($isunknown(got)) begin
        report_mismatch($sformatf("unknown bits in response %h", got));
        return;
      end
      check_field("status", got.status, want.status);
      check_field("start_conversion", got.start_conversion, want.start_conversion);
      check_field("start_channel", got.start_channel, want.start_channel);
      check_field("done_port", got.done_port, want.done_port);
      check_field("done_client", got.done_client, want.done_client);
      check_field("done_value", got.done_value, want.done_value);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_req_t     in_req_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_rsp_t    out_rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  conversion_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  round_robin_adc_request_scheduler i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // both channels are observed at the rising edge, before the dut updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_response(out_rsp_o);
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_request(in_req_i);
      end
    end
  end

  // result side back-pressure: the mode changes at random so that
  // free-flowing stretches alternate with light, heavy and periodic stalls
  int stall_mode = 0;
  int stall_span = 0;
  int stall_tick = 0;
  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(16, 80);
    end
    stall_span--;
    stall_tick++;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= (stall_tick % 7 < 3);
    endcase
  end

  function automatic in_req_t conv_request(logic [3:0] port);
    in_req_t r;
    r.cmd    = CMD_REQUEST;
    r.port   = port;
    r.sample = 10'($urandom);
    return r;
  endfunction

  function automatic in_req_t conv_done(logic [9:0] sample);
    in_req_t r;
    r.cmd    = CMD_DONE;
    r.port   = 4'($urandom);
    r.sample = sample;
    return r;
  endfunction

  // mostly legal traffic, with some out-of-range ports and stray completions
  function automatic in_req_t random_request();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      return conv_request(4'($urandom_range(PORTS, 15)));
    end else if (roll < 12) begin
      return conv_done(10'($urandom));
    end else if (sb.pending_ports() != '0 && roll < 55) begin
      return conv_done(10'($urandom));
    end
    return conv_request(4'($urandom_range(0, PORTS - 1)));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(in_req_t r);
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // wait until every owed response has come back, then a little more
  task automatic drain();
    idle_cycles(1);
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_map(cfg_idx_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_map(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  logic [7:0]  chan_settings[PHASES]   = '{8'h00, 8'hFF, 8'h1B, 8'hE4, 8'h00};
  logic [31:0] client_settings[PHASES] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                          32'h8001_7FFE, 32'h0, 32'h0};

  initial begin
    int burst_left;
    chan_settings[4]   = 8'($urandom);
    client_settings[3] = $urandom;
    client_settings[4] = $urandom;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: spurious completion, range edges, busy port, rotation and wrap
    send_request(conv_done(10'h3FF));
    send_request(conv_request(4'd15));
    send_request(conv_request(4'(PORTS)));
    send_request(conv_request(4'd0));
    send_request(conv_request(4'd0));
    send_request(conv_request(4'd3));
    send_request(conv_request(4'd2));
    send_request(conv_request(4'd1));
    send_request(conv_done(10'h000));
    send_request(conv_done(10'h3FF));
    send_request(conv_done(10'h155));
    send_request(conv_done(10'h2AA));
    // queue empty now, completion is stray
    send_request(conv_done(10'h0F0));
    send_request(conv_request(4'd3));
    send_request(conv_request(4'd1));
    send_request(conv_request(4'd2));
    // search wraps from port 3 past port 0 to port 1
    send_request(conv_done(10'h30F));
    send_request(conv_request(4'd3));
    send_request(conv_done(10'h001));
    send_request(conv_done(10'h200));
    send_request(conv_done(10'h3C3));
    send_request(conv_done(10'h03C));

    // random phases, each under its own map setting
    burst_left = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      // upper data bits are junk that the channel map must ignore
      write_map(CFG_CHANNEL_MAP, {24'($urandom), chan_settings[ph]});
      write_map(CFG_CLIENT_MAP, client_settings[ph]);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (burst_left == 0) begin
          idle_cycles(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
          burst_left = $urandom_range(1, 20);
        end
        send_request(random_request());
        burst_left--;
      end
    end

    drain();
    repeat (10) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[%0t] timeout, %0d responses outstanding", $realtime, sb.outstanding());
    $display("simulation failed");
    $finish;
  end

endmodule
